// File: rtl/psba_pkg.sv
// types, constants and codes shared by the power spectrum bin accumulator
package psba_pkg;

   // field widths
   localparam int GRID_W     = 11;
   localparam int BINCNT_W   = 8;
   localparam int MODE_W     = 2;
   localparam int ACT_W      = 2;
   localparam int IDX_W      = 10;
   localparam int SEL_W      = 7;
   localparam int DATA_W     = 24;
   localparam int POWER_W    = 64;
   localparam int COUNT_W    = 30;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // datapath widths
   localparam int MUL_W     = 32;
   localparam int PROD_W    = 64;
   localparam int K2_W      = 22;
   localparam int PW_W      = 48;
   localparam int NBSQ_W    = 16;
   localparam int NSQ_W     = 22;
   localparam int NUM_W     = 40;
   localparam int DEN_W     = 24;
   localparam int ROOT_W    = 20;
   localparam int SQREM_W   = 22;
   localparam int LGM_W     = 31;
   localparam int LGE_W     = 5;
   localparam int LGF_W     = 8;
   localparam int LG_W      = LGE_W + LGF_W;
   localparam int STEP_W    = 3;
   localparam int DCNT_W    = 6;
   localparam int SCNT_W    = 5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [LG_W-1:0]    LG_OFFSET = 13'd512;

   // reset values of the registers
   localparam logic [GRID_W-1:0]   GRID_RESET = 11'd100;
   localparam logic [BINCNT_W-1:0] BINS_RESET = 8'd80;
   localparam logic [MODE_W-1:0]   MODE_RESET = 2'd1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BINS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 2'd2;

   // binning modes
   localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SCALED = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOG    = 2'd2;

   typedef enum logic [ACT_W-1:0] {
      ACT_ACCUM = 2'd0,
      ACT_READ  = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_PREP,
      ST_LOGM,
      ST_LOGA,
      ST_LMUL,
      ST_LDIV,
      ST_DIV,
      ST_SQRT,
      ST_SAT,
      ST_RD,
      ST_WR
   } state_type;

   typedef struct packed {
      logic [ACT_W-1:0]         action;
      logic [IDX_W-1:0]         x_index;
      logic [IDX_W-1:0]         y_index;
      logic [IDX_W-1:0]         z_index;
      logic signed [DATA_W-1:0] real_part;
      logic signed [DATA_W-1:0] imag_part;
      logic [SEL_W-1:0]         bin_select;
   } req_type;

   typedef struct packed {
      logic [SEL_W-1:0]   bin_index;
      logic [POWER_W-1:0] power_sum;
      logic [COUNT_W-1:0] sample_count;
   } rsp_type;

endpackage

// File: rtl/psba_ram.sv
// generic single-port-write ram with registered read
module psba_ram #(
   parameter int WIDTH = 94,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/power_spectrum_bin_accumulator_core.sv
// top level of the power spectrum bin accumulator
//
// Usage: an item is taken when start is high and busy is low. Action accumulate
// folds re^2 + im^2 of one coefficient into the radial bin of its grid indices
// and bumps that bin's count; read returns one bin; clear zeroes all bins.
// Every item gives one result on rsp_data, marked by rsp_strobe for one cycle;
// the receiver cannot stall it.
// Clear and unknown actions answer straight from idle; read passes the RD and WR
// states; accumulate first runs the shared multiplier, then the one-bit-a-cycle
// divider and square root in scaled mode, the square root in linear mode, and the
// log2 steps and divider in log mode (skipped when k2 is zero), then RD and WR.
// One item is in flight at a time.
// Bins live in one ram of MAX_BINS entries read, updated and written back;
// a valid bit per bin makes unwritten bins read as zero.
// Reset (synchronous) restores grid size 100, 80 bins and scaled mode and
// empties all bins at once; no clearing pass is needed. Configuration is
// written through csr_wr_en / csr_index / csr_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
module power_spectrum_bin_accumulator_core #(
   parameter int MAX_GRID = 1024,
   parameter int MAX_BINS = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  psba_pkg::req_type                   req_data,
   output logic                                rsp_strobe,
   output psba_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [psba_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [psba_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int BIN_AW = $clog2(MAX_BINS);
   localparam int ENTRY_W = psba_pkg::POWER_W + psba_pkg::COUNT_W;

   // configuration registers
   logic [psba_pkg::GRID_W-1:0]   grid_ff;
   logic [psba_pkg::BINCNT_W-1:0] bins_ff;
   logic [psba_pkg::MODE_W-1:0]   mode_cfg_ff;

   // control and datapath registers
   psba_pkg::state_type  state_ff, state_in;
   psba_pkg::action_type act_ff, act_in;
   logic [psba_pkg::GRID_W-1:0]   n_ff, n_in;
   logic [psba_pkg::BINCNT_W-1:0] nb_ff, nb_in;
   logic [psba_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [psba_pkg::IDX_W-1:0]    magx_ff, magx_in, magy_ff, magy_in, magz_ff, magz_in;
   logic [psba_pkg::DATA_W-1:0]   mre_ff, mre_in, mim_ff, mim_in;
   logic [psba_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [psba_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [psba_pkg::K2_W-1:0]     k2_ff, k2_in;
   logic [psba_pkg::PW_W-1:0]     pw_ff, pw_in;
   logic [psba_pkg::NBSQ_W-1:0]   nbsq_ff, nbsq_in;
   logic [psba_pkg::NSQ_W-1:0]    nsq_ff, nsq_in;
   logic [psba_pkg::NUM_W-1:0]    num_ff, num_in;
   logic [psba_pkg::LGM_W-1:0]    lgm_ff, lgm_in;
   logic [psba_pkg::LGE_W-1:0]    lge_ff, lge_in;
   logic [psba_pkg::LGF_W-1:0]    lgf_ff, lgf_in;
   logic [psba_pkg::STEP_W-1:0]   lgcnt_ff, lgcnt_in;
   logic                          lgsel_ff, lgsel_in;
   logic [psba_pkg::LG_W-1:0]     lg1_ff, lg1_in, lgden_ff, lgden_in;
   logic [psba_pkg::NUM_W-1:0]    dq_ff, dq_in;
   logic [psba_pkg::DEN_W-1:0]    dr_ff, dr_in, dden_ff, dden_in;
   logic [psba_pkg::DCNT_W-1:0]   dcnt_ff, dcnt_in;
   logic                          dlog_ff, dlog_in;
   logic [psba_pkg::NUM_W-1:0]    sx_ff, sx_in;
   logic [psba_pkg::SQREM_W-1:0]  sr_ff, sr_in;
   logic [psba_pkg::ROOT_W-1:0]   sroot_ff, sroot_in;
   logic [psba_pkg::SCNT_W-1:0]   scnt_ff, scnt_in;
   logic [psba_pkg::NUM_W-1:0]    val_ff, val_in;
   logic [psba_pkg::BINCNT_W-1:0] bin_ff, bin_in;
   logic                          oob_ff, oob_in;
   logic [MAX_BINS-1:0]           valid_ff, valid_in;
   psba_pkg::rsp_type             rsp_ff, rsp_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;

   // combinational helpers
   logic                          accept;
   logic [psba_pkg::GRID_W-1:0]   n_eff;
   logic [psba_pkg::BINCNT_W-1:0] nb_eff;
   logic [psba_pkg::MUL_W-1:0]    opa, opb;
   logic [psba_pkg::PROD_W-1:0]   mult_res;
   logic [psba_pkg::DEN_W-1:0]    log_x;
   logic [psba_pkg::LGE_W-1:0]    log_e;
   logic [psba_pkg::LGM_W-1:0]    log_m;
   logic [31:0]                   lg_t;
   logic [psba_pkg::LGF_W-1:0]    lgf_next;
   logic [psba_pkg::LG_W-1:0]     lg_val;
   logic [psba_pkg::DEN_W:0]      div_sh;
   logic                          div_bit;
   logic [psba_pkg::NUM_W-1:0]    dq_next;
   logic [psba_pkg::SQREM_W+1:0]  sq_sh, sq_trial;
   logic                          sq_bit;
   logic [psba_pkg::ROOT_W-1:0]   sroot_next;
   logic [BIN_AW-1:0]             ram_addr;
   logic                          ram_wr_en, ram_rd_en;
   logic [ENTRY_W-1:0]            ram_wr_data, ram_rd_data;
   logic                          cur_valid;
   logic [psba_pkg::POWER_W-1:0]  old_pw, new_pw;
   logic [psba_pkg::COUNT_W-1:0]  old_cnt, new_cnt;
   logic [psba_pkg::POWER_W:0]    pw_sum;
   logic [psba_pkg::BINCNT_W-1:0] nb_m1;

   // magnitude of a wrapped frequency index
   function automatic logic [psba_pkg::IDX_W-1:0] fold_mag(
      input logic [psba_pkg::IDX_W-1:0]  idx,
      input logic [psba_pkg::GRID_W-1:0] n
   );
      logic signed [psba_pkg::GRID_W:0] diff;
      diff = $signed({2'b00, idx}) - $signed({1'b0, n});
      if ({1'b0, idx} > (n >> 1)) begin
         fold_mag = diff[psba_pkg::GRID_W] ? psba_pkg::IDX_W'(-diff)
                                           : diff[psba_pkg::IDX_W-1:0];
      end else begin
         fold_mag = idx;
      end
   endfunction

   // magnitude of a signed coefficient part
   function automatic logic [psba_pkg::DATA_W-1:0] abs_mag(
      input logic [psba_pkg::DATA_W-1:0] v
   );
      abs_mag = v[psba_pkg::DATA_W-1] ? (~v + 24'd1) : v;
   endfunction

   // bin store
   psba_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   assign accept     = start && (state_ff == psba_pkg::ST_IDLE);
   assign busy       = (state_ff != psba_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff     <= psba_pkg::GRID_RESET;
         bins_ff     <= psba_pkg::BINS_RESET;
         mode_cfg_ff <= psba_pkg::MODE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            psba_pkg::CSR_GRID: grid_ff     <= csr_wdata;
            psba_pkg::CSR_BINS: bins_ff     <= csr_wdata[psba_pkg::BINCNT_W-1:0];
            psba_pkg::CSR_MODE: mode_cfg_ff <= csr_wdata[psba_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp grid size and bin count into their working ranges
   always_comb begin
      if (grid_ff < 11'd2) begin
         n_eff = 11'd2;
      end else if (32'(grid_ff) > MAX_GRID) begin
         n_eff = psba_pkg::GRID_W'(MAX_GRID);
      end else begin
         n_eff = grid_ff;
      end
      if (bins_ff == '0) begin
         nb_eff = 8'd1;
      end else if (32'(bins_ff) > MAX_BINS) begin
         nb_eff = psba_pkg::BINCNT_W'(MAX_BINS);
      end else begin
         nb_eff = bins_ff;
      end
   end

   // shared multiplier operand selection
   always_comb begin
      opa = '0;
      opb = '0;
      case (state_ff)
         psba_pkg::ST_MUL: begin
            case (step_ff)
               3'd0: begin opa = 32'(magx_ff); opb = 32'(magx_ff); end
               3'd1: begin opa = 32'(magy_ff); opb = 32'(magy_ff); end
               3'd2: begin opa = 32'(magz_ff); opb = 32'(magz_ff); end
               3'd3: begin opa = 32'(mre_ff);  opb = 32'(mre_ff);  end
               3'd4: begin opa = 32'(mim_ff);  opb = 32'(mim_ff);  end
               3'd5: begin opa = 32'(nb_ff);   opb = 32'(nb_ff);   end
               3'd6: begin opa = 32'(n_ff);    opb = 32'(n_ff);    end
               default: begin opa = 32'(k2_ff); opb = 32'(nbsq_ff); end
            endcase
         end
         psba_pkg::ST_LOGM: begin
            opa = 32'(lgm_ff);
            opb = 32'(lgm_ff);
         end
         psba_pkg::ST_LMUL: begin
            opa = 32'(lg1_ff);
            opb = 32'(nb_ff);
         end
         default: ;
      endcase
   end

   assign mult_res = opa * opb;

   // log2 setup: msb position and normalized mantissa
   always_comb begin
      log_x = (state_ff == psba_pkg::ST_PREP) ? psba_pkg::DEN_W'(k2_ff)
                                              : psba_pkg::DEN_W'(nsq_ff) +
                                                psba_pkg::DEN_W'({nsq_ff, 1'b0});
      log_e = '0;
      for (int i = 0; i < psba_pkg::DEN_W; i++) begin
         if (log_x[i]) begin
            log_e = psba_pkg::LGE_W'(i);
         end
      end
      log_m = psba_pkg::LGM_W'({7'b0, log_x} << (5'd30 - log_e));
   end

   // log2 fraction round, divider step and square root step
   always_comb begin
      lg_t     = prod_ff[61:30];
      lgf_next = {lgf_ff[psba_pkg::LGF_W-2:0], lg_t[31]};
      lg_val   = {lge_ff, lgf_next};

      div_sh  = {dr_ff, dq_ff[psba_pkg::NUM_W-1]};
      div_bit = (div_sh >= {1'b0, dden_ff});
      dq_next = {dq_ff[psba_pkg::NUM_W-2:0], div_bit};

      sq_sh      = {sr_ff, sx_ff[psba_pkg::NUM_W-1 -: 2]};
      sq_trial   = {2'b0, sroot_ff, 2'b01};
      sq_bit     = (sq_sh >= sq_trial);
      sroot_next = {sroot_ff[psba_pkg::ROOT_W-2:0], sq_bit};
   end

   // bin update
   always_comb begin
      ram_addr    = BIN_AW'(bin_ff);
      cur_valid   = valid_ff[ram_addr];
      old_pw      = cur_valid ? ram_rd_data[ENTRY_W-1 -: psba_pkg::POWER_W] : '0;
      old_cnt     = cur_valid ? ram_rd_data[psba_pkg::COUNT_W-1:0] : '0;
      pw_sum      = {1'b0, old_pw} + 65'(pw_ff);
      new_pw      = pw_sum[psba_pkg::POWER_W] ? '1 : pw_sum[psba_pkg::POWER_W-1:0];
      new_cnt     = (old_cnt == psba_pkg::COUNT_MAX) ? old_cnt : old_cnt + 30'd1;
      ram_wr_data = {new_pw, new_cnt};
      ram_rd_en   = (state_ff == psba_pkg::ST_RD);
      ram_wr_en   = (state_ff == psba_pkg::ST_WR) && (act_ff == psba_pkg::ACT_ACCUM);
      nb_m1       = nb_ff - 8'd1;
   end

   // sequencer: next state and datapath
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      n_in          = n_ff;
      nb_in         = nb_ff;
      mode_in       = mode_ff;
      magx_in       = magx_ff;
      magy_in       = magy_ff;
      magz_in       = magz_ff;
      mre_in        = mre_ff;
      mim_in        = mim_ff;
      step_in       = step_ff;
      prod_in       = prod_ff;
      k2_in         = k2_ff;
      pw_in         = pw_ff;
      nbsq_in       = nbsq_ff;
      nsq_in        = nsq_ff;
      num_in        = num_ff;
      lgm_in        = lgm_ff;
      lge_in        = lge_ff;
      lgf_in        = lgf_ff;
      lgcnt_in      = lgcnt_ff;
      lgsel_in      = lgsel_ff;
      lg1_in        = lg1_ff;
      lgden_in      = lgden_ff;
      dq_in         = dq_ff;
      dr_in         = dr_ff;
      dden_in       = dden_ff;
      dcnt_in       = dcnt_ff;
      dlog_in       = dlog_ff;
      sx_in         = sx_ff;
      sr_in         = sr_ff;
      sroot_in      = sroot_ff;
      scnt_in       = scnt_ff;
      val_in        = val_ff;
      bin_in        = bin_ff;
      oob_in        = oob_ff;
      valid_in      = valid_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;

      case (state_ff)
         psba_pkg::ST_IDLE: begin
            if (accept) begin
               act_in  = psba_pkg::action_type'(req_data.action);
               n_in    = n_eff;
               nb_in   = nb_eff;
               mode_in = mode_cfg_ff;
               magx_in = fold_mag(req_data.x_index, n_eff);
               magy_in = fold_mag(req_data.y_index, n_eff);
               magz_in = req_data.z_index;
               mre_in  = abs_mag(req_data.real_part);
               mim_in  = abs_mag(req_data.imag_part);
               case (psba_pkg::action_type'(req_data.action))
                  psba_pkg::ACT_ACCUM: begin
                     step_in  = '0;
                     k2_in    = '0;
                     pw_in    = '0;
                     state_in = psba_pkg::ST_MUL;
                  end
                  psba_pkg::ACT_READ: begin
                     bin_in   = psba_pkg::BINCNT_W'(req_data.bin_select);
                     oob_in   = (32'(req_data.bin_select) >= MAX_BINS);
                     state_in = psba_pkg::ST_RD;
                  end
                  psba_pkg::ACT_CLEAR: begin
                     valid_in      = '0;
                     rsp_in        = '0;
                     rsp_strobe_in = 1'b1;
                  end
                  default: begin
                     rsp_in        = '0;
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         psba_pkg::ST_MUL: begin
            prod_in  = mult_res;
            state_in = psba_pkg::ST_ACC;
         end
         psba_pkg::ST_ACC: begin
            case (step_ff)
               3'd0, 3'd1, 3'd2: k2_in = k2_ff + prod_ff[psba_pkg::K2_W-1:0];
               3'd3, 3'd4:       pw_in = pw_ff + prod_ff[psba_pkg::PW_W-1:0];
               3'd5:             nbsq_in = prod_ff[psba_pkg::NBSQ_W-1:0];
               3'd6:             nsq_in = prod_ff[psba_pkg::NSQ_W-1:0];
               default:          num_in = {prod_ff[psba_pkg::NUM_W-3:0], 2'b00};
            endcase
            step_in  = step_ff + 3'd1;
            state_in = (step_ff == 3'd7) ? psba_pkg::ST_PREP : psba_pkg::ST_MUL;
         end
         psba_pkg::ST_PREP: begin
            case (mode_ff)
               psba_pkg::MODE_SCALED: begin
                  dq_in    = num_ff;
                  dr_in    = '0;
                  dden_in  = psba_pkg::DEN_W'(nsq_ff) + psba_pkg::DEN_W'({nsq_ff, 1'b0});
                  dcnt_in  = '0;
                  dlog_in  = 1'b0;
                  state_in = psba_pkg::ST_DIV;
               end
               psba_pkg::MODE_LOG: begin
                  if (k2_ff == '0) begin
                     val_in   = '0;
                     state_in = psba_pkg::ST_SAT;
                  end else begin
                     lge_in   = log_e;
                     lgm_in   = log_m;
                     lgf_in   = '0;
                     lgcnt_in = '0;
                     lgsel_in = 1'b0;
                     state_in = psba_pkg::ST_LOGM;
                  end
               end
               default: begin
                  sx_in    = psba_pkg::NUM_W'(k2_ff);
                  sr_in    = '0;
                  sroot_in = '0;
                  scnt_in  = '0;
                  state_in = psba_pkg::ST_SQRT;
               end
            endcase
         end
         psba_pkg::ST_LOGM: begin
            prod_in  = mult_res;
            state_in = psba_pkg::ST_LOGA;
         end
         psba_pkg::ST_LOGA: begin
            lgf_in   = lgf_next;
            lgm_in   = lg_t[31] ? lg_t[31:1] : lg_t[30:0];
            lgcnt_in = lgcnt_ff + 3'd1;
            state_in = psba_pkg::ST_LOGM;
            if (lgcnt_ff == 3'd7) begin
               if (!lgsel_ff) begin
                  // k2 done, start on 3 * n^2
                  lg1_in   = lg_val;
                  lge_in   = log_e;
                  lgm_in   = log_m;
                  lgf_in   = '0;
                  lgcnt_in = '0;
                  lgsel_in = 1'b1;
               end else begin
                  lgden_in = lg_val - psba_pkg::LG_OFFSET;
                  state_in = psba_pkg::ST_LMUL;
               end
            end
         end
         psba_pkg::ST_LMUL: begin
            prod_in  = mult_res;
            state_in = psba_pkg::ST_LDIV;
         end
         psba_pkg::ST_LDIV: begin
            dq_in    = psba_pkg::NUM_W'(prod_ff[psba_pkg::LG_W+psba_pkg::BINCNT_W-1:0]);
            dr_in    = '0;
            dden_in  = psba_pkg::DEN_W'(lgden_ff);
            dcnt_in  = '0;
            dlog_in  = 1'b1;
            state_in = psba_pkg::ST_DIV;
         end
         psba_pkg::ST_DIV: begin
            dr_in   = div_bit ? psba_pkg::DEN_W'(div_sh - {1'b0, dden_ff})
                              : div_sh[psba_pkg::DEN_W-1:0];
            dq_in   = dq_next;
            dcnt_in = dcnt_ff + 6'd1;
            if (dcnt_ff == 6'(psba_pkg::NUM_W - 1)) begin
               if (dlog_ff) begin
                  val_in   = dq_next;
                  state_in = psba_pkg::ST_SAT;
               end else begin
                  sx_in    = dq_next;
                  sr_in    = '0;
                  sroot_in = '0;
                  scnt_in  = '0;
                  state_in = psba_pkg::ST_SQRT;
               end
            end
         end
         psba_pkg::ST_SQRT: begin
            sr_in    = sq_bit ? psba_pkg::SQREM_W'(sq_sh - sq_trial)
                              : psba_pkg::SQREM_W'(sq_sh);
            sroot_in = sroot_next;
            sx_in    = {sx_ff[psba_pkg::NUM_W-3:0], 2'b00};
            scnt_in  = scnt_ff + 5'd1;
            if (scnt_ff == 5'(psba_pkg::ROOT_W - 1)) begin
               val_in   = psba_pkg::NUM_W'(sroot_next);
               state_in = psba_pkg::ST_SAT;
            end
         end
         psba_pkg::ST_SAT: begin
            bin_in   = (val_ff > psba_pkg::NUM_W'(nb_m1)) ? nb_m1
                                                         : val_ff[psba_pkg::BINCNT_W-1:0];
            oob_in   = 1'b0;
            state_in = psba_pkg::ST_RD;
         end
         psba_pkg::ST_RD: begin
            state_in = psba_pkg::ST_WR;
         end
         psba_pkg::ST_WR: begin
            rsp_in.bin_index = bin_ff[psba_pkg::SEL_W-1:0];
            if (act_ff == psba_pkg::ACT_ACCUM) begin
               valid_in[ram_addr]  = 1'b1;
               rsp_in.power_sum    = new_pw;
               rsp_in.sample_count = new_cnt;
            end else begin
               rsp_in.power_sum    = oob_ff ? '0 : old_pw;
               rsp_in.sample_count = oob_ff ? '0 : old_cnt;
            end
            rsp_strobe_in = 1'b1;
            state_in      = psba_pkg::ST_IDLE;
         end
         default: state_in = psba_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= psba_pkg::ST_IDLE;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      n_ff     <= n_in;
      nb_ff    <= nb_in;
      mode_ff  <= mode_in;
      magx_ff  <= magx_in;
      magy_ff  <= magy_in;
      magz_ff  <= magz_in;
      mre_ff   <= mre_in;
      mim_ff   <= mim_in;
      step_ff  <= step_in;
      prod_ff  <= prod_in;
      k2_ff    <= k2_in;
      pw_ff    <= pw_in;
      nbsq_ff  <= nbsq_in;
      nsq_ff   <= nsq_in;
      num_ff   <= num_in;
      lgm_ff   <= lgm_in;
      lge_ff   <= lge_in;
      lgf_ff   <= lgf_in;
      lgcnt_ff <= lgcnt_in;
      lgsel_ff <= lgsel_in;
      lg1_ff   <= lg1_in;
      lgden_ff <= lgden_in;
      dq_ff    <= dq_in;
      dr_ff    <= dr_in;
      dden_ff  <= dden_in;
      dcnt_ff  <= dcnt_in;
      dlog_ff  <= dlog_in;
      sx_ff    <= sx_in;
      sr_ff    <= sr_in;
      sroot_ff <= sroot_in;
      scnt_ff  <= scnt_in;
      val_ff   <= val_in;
      bin_ff   <= bin_in;
      oob_ff   <= oob_in;
      rsp_ff   <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   // an accepted accumulate keeps the block busy in the next cycle
   a_accum_busy: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.action == psba_pkg::ACT_ACCUM) |=> busy)
      else $error("accumulate item did not start the sequencer");

   // the bin written back always lies below the bin count in use
   a_bin_range: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (bin_ff < nb_ff))
      else $error("bin index not saturated");

   // read and write of the bin store never share a cycle
   a_ram_excl: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("bin store read and write overlap");

   // every write-back is preceded by a read of the same bin
   a_rmw_order: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> $past(ram_rd_en) && $stable(bin_ff))
      else $error("bin write without matching read");
`endif

endmodule

// File: bench/power_spectrum_bin_accumulator_core_tb.sv
// self-checking bench for the power spectrum bin accumulator core
`timescale 1ns / 1ps

module power_spectrum_bin_accumulator_core_tb;
   import psba_pkg::*;

   localparam int NUM_BINS   = 128;
   localparam int GRID_LIMIT = 1024;
   localparam int CYCLE_CAP  = 2000000;
   localparam int DRAIN_WAIT = 100;

   // expected bin contents and the queue of results still owed
   class spectrum_scoreboard;
      logic [POWER_W-1:0]  power_bins [NUM_BINS];
      logic [COUNT_W-1:0]  count_bins [NUM_BINS];
      logic [GRID_W-1:0]   grid_reg;
      logic [BINCNT_W-1:0] bins_reg;
      logic [MODE_W-1:0]   mode_reg;
      rsp_type             owed [$];
      int                  errors;

      function new();
         grid_reg = GRID_RESET;
         bins_reg = BINS_RESET;
         mode_reg = MODE_RESET;
         errors   = 0;
         wipe();
      endfunction

      function void wipe();
         for (int i = 0; i < NUM_BINS; i++) begin
            power_bins[i] = '0;
            count_bins[i] = '0;
         end
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_GRID) grid_reg = val;
         else if (idx == CSR_BINS) bins_reg = val[BINCNT_W-1:0];
         else if (idx == CSR_MODE) mode_reg = val[MODE_W-1:0];
      endfunction

      function longint unsigned int_sqrt(longint unsigned x);
         longint unsigned root, bitv;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > x) bitv >>= 2;
         while (bitv != 0) begin
            if (x >= root + bitv) begin
               x -= root + bitv;
               root = (root >> 1) + bitv;
            end else begin
               root >>= 1;
            end
            bitv >>= 2;
         end
         return root;
      endfunction

      // log2 with 8 fraction bits by repeated squaring of the mantissa
      function longint unsigned log2_frac8(longint unsigned x);
         longint unsigned ex, mant, frac;
         ex = 0;
         frac = 0;
         while (ex < 29 && (x >> (ex + 1)) != 0) ex++;
         mant = (x << (30 - ex)) & 64'h7FFF_FFFF;
         for (int i = 0; i < 8; i++) begin
            mant = (mant * mant) >> 30;
            frac <<= 1;
            if (mant >= (64'd1 << 31)) begin
               frac |= 1;
               mant >>= 1;
            end
         end
         return ex * 256 + frac;
      endfunction

      function longint signed fold_freq(longint unsigned idx, longint unsigned n);
         if (idx > n / 2) return longint'(idx) - longint'(n);
         return longint'(idx);
      endfunction

      // work out the result of one accepted item and update the bins
      function void note_item(req_type item);
         rsp_type         res;
         longint unsigned n, nb, k2, bin, pw, sum;
         longint signed   kx, ky, kz, re, im;
         res = '0;
         case (action_type'(item.action))
            ACT_ACCUM: begin
               n  = grid_reg;
               nb = bins_reg;
               if (n < 2) n = 2;
               if (n > GRID_LIMIT) n = GRID_LIMIT;
               if (nb < 1) nb = 1;
               if (nb > NUM_BINS) nb = NUM_BINS;
               kx = fold_freq(item.x_index, n);
               ky = fold_freq(item.y_index, n);
               kz = longint'(item.z_index);
               k2 = kx * kx + ky * ky + kz * kz;
               if (mode_reg == MODE_SCALED)
                  bin = int_sqrt((4 * k2 * nb * nb) / (3 * n * n));
               else if (mode_reg == MODE_LOG)
                  bin = (k2 == 0) ? 0 :
                        (log2_frac8(k2) * nb) / (log2_frac8(3 * n * n) - 512);
               else
                  bin = int_sqrt(k2);
               if (bin > nb - 1) bin = nb - 1;
               re  = item.real_part;
               im  = item.imag_part;
               pw  = re * re + im * im;
               sum = power_bins[bin] + pw;
               if (sum < power_bins[bin]) sum = '1;
               power_bins[bin] = sum;
               if (count_bins[bin] != COUNT_MAX) count_bins[bin]++;
               res.bin_index    = bin[SEL_W-1:0];
               res.power_sum    = power_bins[bin];
               res.sample_count = count_bins[bin];
            end
            ACT_READ: begin
               res.bin_index    = item.bin_select;
               res.power_sum    = power_bins[item.bin_select];
               res.sample_count = count_bins[item.bin_select];
            end
            ACT_CLEAR: wipe();
            default: ;
         endcase
         owed.push_back(res);
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         $display("error: %s got %0h expected %0h", what, got, want);
         errors++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            report_mismatch("result with none pending", 64'(got.bin_index), 64'd0);
         end else begin
            want = owed.pop_front();
            if (got.bin_index !== want.bin_index)
               report_mismatch("bin_index", 64'(got.bin_index), 64'(want.bin_index));
            if (got.power_sum !== want.power_sum)
               report_mismatch("power_sum", got.power_sum, want.power_sum);
            if (got.sample_count !== want.sample_count)
               report_mismatch("sample_count", 64'(got.sample_count),
                               64'(want.sample_count));
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_strobe;
   rsp_type               rsp_data;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   spectrum_scoreboard sb;
   int                 cycle_count;
   bit                 idle_on;

   power_spectrum_bin_accumulator_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watch accepts, register writes and results at each rising edge
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("power_spectrum_bin_accumulator_core: mismatch");
         $finish;
      end
      if (!reset) begin
         if (csr_wr_en) sb.write_reg(csr_index, csr_wdata);
         if (start && !busy) sb.note_item(req_data);
         if (rsp_strobe) sb.check_result(rsp_data);
      end
   end

   // present one item and hold it until it is taken
   task send_item(req_type item);
      if (idle_on && $urandom_range(99) < 11) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
   endtask

   task drain();
      @(negedge clock);
      start <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic req_type accum_item(int x, int y, int z, int re, int im);
      req_type r;
      r = '0;
      r.action    = ACT_ACCUM;
      r.x_index   = IDX_W'(x);
      r.y_index   = IDX_W'(y);
      r.z_index   = IDX_W'(z);
      r.real_part = DATA_W'(re);
      r.imag_part = DATA_W'(im);
      return r;
   endfunction

   function automatic req_type random_item(int n);
      req_type     r;
      int          pick;
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(req_type)-1:0];
      pick = $urandom_range(99);
      if (pick < 80) begin
         r.action = ACT_ACCUM;
         // mostly indices inside the grid so every bin gets traffic
         if ($urandom_range(3) != 0) begin
            r.x_index = IDX_W'($urandom_range(n - 1));
            r.y_index = IDX_W'($urandom_range(n - 1));
            r.z_index = IDX_W'($urandom_range(n / 2));
         end
         if ($urandom_range(15) == 0) r.real_part = 24'h800000;
         if ($urandom_range(15) == 0) r.imag_part = 24'h7FFFFF;
      end else if (pick < 93) begin
         r.action = ACT_READ;
      end else if (pick < 96) begin
         r.action = ACT_CLEAR;
      end else begin
         r.action = ACT_NOP;
      end
      return r;
   endfunction

   // directed corners at the reset settings
   task directed_items();
      req_type r;
      send_item(accum_item(0, 0, 0, 0, 0));
      send_item(accum_item(1023, 1023, 1023, -8388608, -8388608));
      send_item(accum_item(50, 51, 0, 8388607, 8388607));
      send_item(accum_item(51, 50, 50, -8388608, 8388607));
      send_item(accum_item(1, 99, 1, 1, -1));
      send_item(accum_item(0, 0, 512, 12345, -54321));
      send_item(accum_item(1023, 0, 0, 8388607, -8388608));
      r = '0;
      r.action = ACT_READ;
      for (int b = 0; b < 4; b++) begin
         r.bin_select = SEL_W'(b);
         send_item(r);
      end
      r.bin_select = 7'd79;
      send_item(r);
      r.bin_select = 7'd127;
      send_item(r);
      r.action = ACT_NOP;
      r.bin_select = 7'd5;
      send_item(r);
      r.action = ACT_CLEAR;
      send_item(r);
      r.action = ACT_READ;
      r.bin_select = 7'd79;
      send_item(r);
   endtask

   // grid, bin count and mode for each phase, extremes included
   int grid_set [7] = '{2, 1024, 0, 2047, 64, 1000, 7};
   int bins_set [7] = '{1, 128, 0, 255, 16, 128, 3};
   int mode_set [7] = '{MODE_LINEAR, MODE_LOG, 3, MODE_SCALED, MODE_LOG, MODE_LINEAR,
                        MODE_SCALED};

   initial begin
      int n;
      sb          = new();
      cycle_count = 0;
      idle_on     = 1'b1;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_items();
      for (int k = 0; k < 60; k++) send_item(random_item(100));

      for (int ph = 0; ph < 7; ph++) begin
         // registers change only once the block has gone quiet
         drain();
         write_csr(CSR_GRID, CSR_DATA_W'(grid_set[ph]));
         write_csr(CSR_BINS, CSR_DATA_W'(bins_set[ph]));
         write_csr(CSR_MODE, CSR_DATA_W'(mode_set[ph]));
         n = (grid_set[ph] < 2) ? 2 : (grid_set[ph] > GRID_LIMIT ? GRID_LIMIT : grid_set[ph]);
         idle_on = (ph != 3);
         for (int k = 0; k < 125; k++) send_item(random_item(n));
      end

      drain();
      if (sb.errors == 0 && sb.owed.size() == 0) begin
         $display("power_spectrum_bin_accumulator_core: match");
      end else begin
         $display("power_spectrum_bin_accumulator_core: mismatch");
      end
      $finish;
   end

endmodule
